>>> src/dsb_pkg.sv
// Shared constants, payload types and register codes of the delay-and-sum beamformer.
`default_nettype none
package dsb_pkg;
   localparam int NUM_CHANNELS      = 4;
   localparam int SAMPLE_BITS       = 16;
   localparam int MAX_SHIFT_DEFAULT = 63;
   localparam int SHIFT_W           = 6;
   localparam int COUNT_W           = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SHIFT_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT3 = 3'd4;

   localparam int JOB_DEPTH = 4;
   localparam int RSP_DEPTH = 8;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_ch0;
      logic signed [SAMPLE_BITS-1:0] sample_ch1;
      logic signed [SAMPLE_BITS-1:0] sample_ch2;
      logic signed [SAMPLE_BITS-1:0] sample_ch3;
      logic                          frame_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mono_sample;
      logic                          frame_last;
   } rsp_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0]              mask;
      logic [NUM_CHANNELS-1:0][SHIFT_W-1:0] shift;
   } cfg_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] sample;
      logic [SHIFT_W-1:0]                       wp;
      logic [SHIFT_W-1:0]                       start;
      logic                                     has_out;
      logic                                     fend;
   } job_type;
endpackage
`default_nettype wire

>>> src/dsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dsb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> src/dsb_fifo.sv
// Small register queue with occupancy count.
`default_nettype none
module dsb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           pop_data,
   output logic                            empty,
   output logic      [$clog2(DEPTH+1)-1:0] count
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

>>> src/dsb_csr.sv
// Configuration registers: channel mask and per-channel shifts.
`default_nettype none
module dsb_csr import dsb_pkg::*; #(
   parameter int MAX_SHIFT = MAX_SHIFT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);
   localparam logic [CSR_DATA_W-1:0] SHIFT_LIMIT = CSR_DATA_W'(MAX_SHIFT);

   cfg_type                cfg_ff, cfg_in;
   logic [CSR_DATA_W-1:0]  shift_sat;
   logic                   wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;
   assign shift_sat = (csr_data > SHIFT_LIMIT) ? SHIFT_LIMIT : csr_data;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            CSR_MASK:   cfg_in.mask     = csr_data[NUM_CHANNELS-1:0];
            CSR_SHIFT0: cfg_in.shift[0] = shift_sat;
            CSR_SHIFT1: cfg_in.shift[1] = shift_sat;
            CSR_SHIFT2: cfg_in.shift[2] = shift_sat;
            CSR_SHIFT3: cfg_in.shift[3] = shift_sat;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mask  <= '1;
         cfg_ff.shift <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

>>> src/dsb_front.sv
// Front end: takes sample beats, tracks frame position, builds output jobs.
`default_nettype none
module dsb_front import dsb_pkg::*; #(
   parameter int MAX_SHIFT = MAX_SHIFT_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   output logic         job_push,
   output job_type      job_data,
   input  wire logic    job_full
);
   localparam int PTR_W = $clog2(MAX_SHIFT + 1);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [SHIFT_W-1:0] delay;
   logic               normal;
   logic               accept;

   assign accept   = req_push & ~job_full;
   assign req_full = job_full;
   assign job_push = accept;

   always_comb begin
      delay = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (cfg.mask[c] && (cfg.shift[c] > delay)) begin
            delay = cfg.shift[c];
         end
      end
   end

   assign normal = (count_ff >= COUNT_W'(delay));

   always_comb begin
      job_data.sample[0] = req_data.sample_ch0;
      job_data.sample[1] = req_data.sample_ch1;
      job_data.sample[2] = req_data.sample_ch2;
      job_data.sample[3] = req_data.sample_ch3;
      job_data.wp        = SHIFT_W'(wp_ff);
      job_data.start     = normal ? delay : count_ff[SHIFT_W-1:0];
      job_data.has_out   = normal | req_data.frame_end;
      job_data.fend      = req_data.frame_end;
   end

   always_comb begin
      count_in = count_ff;
      wp_in    = wp_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            count_in = '0;
            wp_in    = '0;
         end else begin
            wp_in = wp_ff + 1'b1;
            if (count_ff < COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wp_ff    <= '0;
      end else begin
         count_ff <= count_in;
         wp_ff    <= wp_in;
      end
   end
endmodule
`default_nettype wire

>>> src/dsb_back.sv
// Back end: writes history, walks output ages, sums and averages channels.
`default_nettype none
module dsb_back import dsb_pkg::*; #(
   parameter int MAX_SHIFT = MAX_SHIFT_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 job_empty,
   input  wire job_type              job_data,
   output logic                      job_pop,
   output logic                      rsp_push,
   output rsp_type                   rsp_data,
   input  wire logic [RSP_CNT_W-1:0] rsp_count
);
   localparam int PTR_W   = $clog2(MAX_SHIFT + 1);
   localparam int RING    = 2 ** PTR_W;
   localparam int USED_W  = $clog2(NUM_CHANNELS + 1);
   localparam int SUM_W   = SAMPLE_BITS + USED_W;
   localparam int MAG_W   = SUM_W - 1;
   localparam int DIV_SH  = MAG_W + USED_W;
   localparam int RECIP_W = DIV_SH + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam int CRED_W  = RSP_CNT_W + 1;

   // reciprocal table: ceil(2^DIV_SH / n), zero for no channel
   logic [RECIP_W-1:0] recip [NUM_CHANNELS+1];
   assign recip[0] = '0;
   for (genvar g = 1; g <= NUM_CHANNELS; g++) begin : g_recip
      localparam logic [63:0] RecipVal = ((64'd1 << DIV_SH) + 64'(g) - 64'd1) / 64'(g);
      assign recip[g] = RecipVal[RECIP_W-1:0];
   end

   logic                     active_ff, active_in;
   logic [SHIFT_W-1:0]       age_ff, age_in;
   logic                     fend_ff, fend_in;
   logic [SHIFT_W-1:0]       wp_ff, wp_in;

   logic                     s1_valid_ff;
   logic [NUM_CHANNELS-1:0]  s1_use_ff, s1_use_in;
   logic                     s1_last_ff;
   logic                     s2_valid_ff;
   logic [SUM_W-1:0]         s2_sum_ff, s2_sum_in;
   logic [USED_W-1:0]        s2_used_ff, s2_used_in;
   logic                     s2_last_ff;
   logic                     s3_valid_ff;
   logic [PROD_W-1:0]        s3_prod_ff, s3_prod_in;
   logic                     s3_neg_ff;
   logic                     s3_last_ff;

   logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] rd_data;
   logic [NUM_CHANNELS-1:0][PTR_W-1:0]       rd_addr;
   logic [CRED_W-1:0]        pending;
   logic                     credit_ok;
   logic                     issue;
   logic                     finishing;
   logic [MAG_W-1:0]         mag;
   logic [MAG_W-1:0]         quot;
   logic [MAG_W-1:0]         signed_quot;

   assign pending = CRED_W'(rsp_count) + CRED_W'(s1_valid_ff) + CRED_W'(s2_valid_ff)
                  + CRED_W'(s3_valid_ff);
   assign credit_ok = (pending < CRED_W'(RSP_DEPTH));
   assign issue     = active_ff & credit_ok;
   assign finishing = issue & (~fend_ff | (age_ff == '0));
   assign job_pop   = ~job_empty & (~active_ff | finishing);

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_hist
      logic [SHIFT_W-1:0] back;
      logic [SHIFT_W-1:0] pos;
      assign back       = age_ff - cfg.shift[c];
      assign pos        = wp_ff - back;
      assign rd_addr[c] = pos[PTR_W-1:0];
      assign s1_use_in[c] = issue & cfg.mask[c] & (age_ff >= cfg.shift[c]);

      dsb_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (RING)
      ) u_ram (
         .clock   (clock),
         .wr_en   (job_pop),
         .wr_addr (job_data.wp[PTR_W-1:0]),
         .wr_data (job_data.sample[c]),
         .rd_addr (rd_addr[c]),
         .rd_data (rd_data[c])
      );
   end

   // advance through the ages of the current job
   always_comb begin
      active_in = active_ff;
      age_in    = age_ff;
      fend_in   = fend_ff;
      wp_in     = wp_ff;
      if (job_pop) begin
         active_in = job_data.has_out;
         age_in    = job_data.start;
         fend_in   = job_data.fend;
         wp_in     = job_data.wp;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (issue) begin
         age_in = age_ff - 1'b1;
      end
   end

   always_comb begin
      logic [SUM_W-1:0] term;
      s2_sum_in  = '0;
      s2_used_in = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         term = s1_use_ff[c]
              ? {{(SUM_W-SAMPLE_BITS){rd_data[c][SAMPLE_BITS-1]}}, rd_data[c]} : '0;
         s2_sum_in  = s2_sum_in + term;
         s2_used_in = s2_used_in + USED_W'(cfg.mask[c]);
      end
   end

   assign mag        = s2_sum_ff[SUM_W-1] ? MAG_W'(-s2_sum_ff) : s2_sum_ff[MAG_W-1:0];
   assign s3_prod_in = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, recip[s2_used_ff]};

   assign quot        = s3_prod_ff[DIV_SH +: MAG_W];
   assign signed_quot = s3_neg_ff ? -quot : quot;
   assign rsp_push    = s3_valid_ff;
   assign rsp_data.mono_sample = signed_quot[SAMPLE_BITS-1:0];
   assign rsp_data.frame_last  = s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      age_ff     <= age_in;
      fend_ff    <= fend_in;
      wp_ff      <= wp_in;
      s1_use_ff  <= s1_use_in;
      s1_last_ff <= fend_ff & (age_ff == '0);
      s2_sum_ff  <= s2_sum_in;
      s2_used_ff <= s2_used_in;
      s2_last_ff <= s1_last_ff;
      s3_prod_ff <= s3_prod_in;
      s3_neg_ff  <= s2_sum_ff[SUM_W-1];
      s3_last_ff <= s2_last_ff;
   end
endmodule
`default_nettype wire

>>> src/delay_and_sum_beamformer.sv
// Top level of the delay-and-sum beamformer.
//
//   channel | direction | handshake            | beat
//   req_    | in        | req_push / req_full  | req_type: four samples, frame_end
//   rsp_    | out       | rsp_pop / rsp_empty  | rsp_type: mono_sample, frame_last
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One input beat per cycle while the job queue has room and each beat yields at most one
// result, with the result queue draining; a frame-end beat holds the back end while it
// flushes its results (up to MAX_SHIFT+1) through each channel's single-read-port history RAM.
// A result passes the job queue, the read, sum and product stages and the result queue.
// Reset clears control state only; history RAMs hold no reset value.
// req_full rises when the 4-entry job queue fills; the back end holds read
// issue while the 8-entry result queue and three pipeline stages could overflow.
`default_nettype none
module delay_and_sum_beamformer import dsb_pkg::*; #(
   parameter int MAX_SHIFT = MAX_SHIFT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire req_type                req_data,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);
   localparam int JOB_W = $bits(job_type);
   localparam int RSP_W = $bits(rsp_type);

   cfg_type                cfg;
   logic                   job_push;
   job_type                job_in;
   logic                   job_full;
   logic                   job_pop;
   logic [JOB_W-1:0]       job_out_raw;
   logic                   job_empty;
   logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
   logic                   rsp_push;
   rsp_type                rsp_in;
   logic                   rsp_full;
   logic [RSP_W-1:0]       rsp_out_raw;
   logic [RSP_CNT_W-1:0]   rsp_count;

   dsb_csr #(
      .MAX_SHIFT (MAX_SHIFT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dsb_front #(
      .MAX_SHIFT (MAX_SHIFT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg),
      .job_push (job_push),
      .job_data (job_in),
      .job_full (job_full)
   );

   dsb_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_raw),
      .empty     (job_empty),
      .count     (job_count)
   );

   dsb_back #(
      .MAX_SHIFT (MAX_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (job_empty),
      .job_data  (job_type'(job_out_raw)),
      .job_pop   (job_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in),
      .rsp_count (rsp_count)
   );

   dsb_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push & ~rsp_full),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_raw),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_data = rsp_type'(rsp_out_raw);
endmodule
`default_nettype wire
